### rtl/text_console_cell_writer_macros.svh
// Assertion helpers for the console cell writer
`ifndef TEXT_CONSOLE_CELL_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_MACROS_SVH
`define TCW_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: check failed");
`define TCW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: check failed");
`endif

### rtl/tcw_pkg.sv
`default_nettype none
package tcw_pkg;
    localparam int MaxCols = 128;
    localparam int MaxRows = 64;
    localparam int ColW = 7;
    localparam int RowW = 6;
    localparam int AddrW = ColW + RowW;
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_MOVE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;
    localparam logic [7:0] CH_BS = 8'd8;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] BLANK = 8'd32;
    localparam logic [7:0] DEF_FORE = 8'd7;
    localparam logic [1:0] REG_COLS = 2'd0;
    localparam logic [1:0] REG_ROWS = 2'd1;
    localparam logic [1:0] REG_TOP  = 2'd2;
    localparam logic [1:0] REG_HGT  = 2'd3;
    typedef enum logic [6:0] {
        ST_INIT  = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_EXEC  = 7'b0000100,
        ST_SCRL  = 7'b0001000,
        ST_FILL  = 7'b0010000,
        ST_CLR   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;
endpackage
`default_nettype wire

### rtl/text_console_cell_writer.sv
// Flow: an accepted print, control, move or read item passes the EXEC and OUT states;
// its result is then registered. A scroll adds SCRL (copy all 128 columns of each row up
// from the row below) and FILL (blank the active columns of the last row). A clear adds
// CLR, writing each active cell via the one cell store port. s_tready is high only in IDLE
// with the result register free. Reset: synchronous active-low; a pass then writes all
// 8192 cells to space/fore 7/back 0, s_tready low. Registers reset to 80,25,0,25.
`default_nettype none
`include "text_console_cell_writer_macros.svh"
module text_console_cell_writer import tcw_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // op[1:0], char_code[9:2], fore_colour[17:10], back_colour[25:18],
    // pos_x[32:26], pos_y[38:33], zero pad
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // cur_col[6:0], cur_row[12:7], did_scroll[13], cell_char[21:14],
    // cell_fore[29:22], cell_back[37:30], zero pad
    output logic [39:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [7:0] cols_reg;
    logic [6:0] rows_reg;
    logic [5:0] top_reg;
    logic [6:0] hgt_reg;
    logic [23:0] mem [0:MaxCols*MaxRows-1];
    logic [23:0] rd_q;
    logic        we;
    logic [AddrW-1:0] waddr, raddr;
    logic [23:0] wdat;

    state_t st_reg;
    logic [AddrW:0] sweep_reg;
    logic [1:0] op_reg;
    logic [7:0] ch_reg, fg_reg, bg_reg;
    logic [6:0] px_reg;
    logic [5:0] py_reg;
    logic [ColW-1:0] ccol_reg;
    logic [RowW-1:0] crow_reg;
    logic [6:0] srow_reg, send_reg;
    logic [ColW:0] scol_reg;
    logic phase_reg;
    logic scr_reg;
    logic [23:0] cell_sel;
    logic [39:0] out_reg;
    logic outv_reg;

    wire wr_cfg = psel && penable && pwrite;
    assign pready = 1'b1;
    always_comb begin
        case (paddr[3:2])
            REG_COLS: prdata = {24'd0, cols_reg};
            REG_ROWS: prdata = {25'd0, rows_reg};
            REG_TOP:  prdata = {26'd0, top_reg};
            default:  prdata = {25'd0, hgt_reg};
        endcase
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= 8'd80; rows_reg <= 7'd25; top_reg <= 6'd0; hgt_reg <= 7'd25;
        end else if (wr_cfg) begin
            case (paddr[3:2])
                REG_COLS: cols_reg <= pwdata[7:0];
                REG_ROWS: rows_reg <= pwdata[6:0];
                REG_TOP:  top_reg <= pwdata[5:0];
                default:  hgt_reg <= pwdata[6:0];
            endcase
        end
    end

    logic [8:0] ecols;
    logic [7:0] erows;
    logic [7:0] rnum, rend;
    always_comb begin
        ecols = (cols_reg == 8'd0) ? 9'd1 :
                ((cols_reg > 8'd128) ? 9'd128 : {1'b0, cols_reg});
        erows = (rows_reg == 7'd0) ? 8'd1 : ((rows_reg > 7'd64) ? 8'd64 : {1'b0, rows_reg});
        rnum = (hgt_reg == 7'd0) ? (erows - {2'b0, top_reg}) : {1'b0, hgt_reg};
        if ({2'b0, top_reg} + rnum > erows) rnum = erows - {2'b0, top_reg};
        rend = {2'b0, top_reg} + rnum;
    end

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdat;
        rd_q <= mem[raddr];
    end

    logic [7:0] nx_col;
    logic [7:0] ny;
    logic nl;
    logic [7:0] maxy;
    logic in_reg_win;
    logic do_store;
    always_comb begin
        in_reg_win = ({2'b0, crow_reg} >= {2'b0, top_reg}) && ({2'b0, crow_reg} < rend);
        maxy = in_reg_win ? rend : erows;
        nl = 1'b0;
        nx_col = {1'b0, ccol_reg};
        do_store = 1'b0;
        case (ch_reg)
            CH_LF: begin nx_col = 8'd0; nl = 1'b1; end
            CH_CR: nx_col = 8'd0;
            CH_TAB: begin
                nx_col = ({1'b0, ccol_reg} + 8'd8) & ~8'd7;
                if ({1'b0, nx_col} >= ecols) begin nx_col = 8'd0; nl = 1'b1; end
            end
            CH_BS: if (ccol_reg != 0) nx_col = {1'b0, ccol_reg} - 8'd1;
            default: begin
                do_store = ({2'b0, ccol_reg} < ecols) && ({2'b0, crow_reg} < erows);
                nx_col = {1'b0, ccol_reg} + 8'd1;
                if ({1'b0, nx_col} >= ecols) begin nx_col = 8'd0; nl = 1'b1; end
            end
        endcase
        ny = {2'b0, crow_reg} + 8'd1;
    end

    always_comb begin
        we = 1'b0; waddr = '0; wdat = '0; raddr = {py_reg, px_reg};
        case (st_reg)
            ST_INIT: begin we = 1'b1; waddr = sweep_reg[AddrW-1:0];
                wdat = {8'd0, DEF_FORE, BLANK}; end
            ST_EXEC: if (op_reg == OP_WRITE && do_store) begin
                we = 1'b1; waddr = {crow_reg, ccol_reg}; wdat = {bg_reg, fg_reg, ch_reg};
            end
            ST_SCRL: begin
                raddr = {srow_reg[5:0] + 6'd1, scol_reg[6:0]};
                if (phase_reg) begin we = 1'b1; waddr = {srow_reg[5:0], scol_reg[6:0]};
                    wdat = rd_q; end
            end
            ST_FILL: begin we = 1'b1; waddr = {srow_reg[5:0], scol_reg[6:0]};
                wdat = {bg_reg, fg_reg, BLANK}; end
            ST_CLR: begin we = 1'b1; waddr = {srow_reg[5:0], scol_reg[6:0]};
                wdat = {bg_reg, DEF_FORE, BLANK}; end
            default: ;
        endcase
    end

    assign cell_sel = (op_reg == OP_READ) ? rd_q : 24'd0;
    assign s_tready = (st_reg == ST_IDLE) && (!outv_reg || m_tready);
    assign m_tvalid = outv_reg;
    assign m_tdata = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_INIT; sweep_reg <= '0; ccol_reg <= '0; crow_reg <= '0;
            outv_reg <= 1'b0; phase_reg <= 1'b0;
        end else begin
            if (outv_reg && m_tready) outv_reg <= 1'b0;
            case (st_reg)
                ST_INIT: begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == (AddrW+1)'(MaxCols*MaxRows-1)) st_reg <= ST_IDLE;
                end
                ST_IDLE: if (s_tvalid && (!outv_reg || m_tready)) begin
                    op_reg <= s_tdata[1:0]; ch_reg <= s_tdata[9:2];
                    fg_reg <= s_tdata[17:10]; bg_reg <= s_tdata[25:18];
                    px_reg <= s_tdata[32:26]; py_reg <= s_tdata[38:33];
                    scr_reg <= 1'b0;
                    st_reg <= ST_EXEC;
                end
                ST_EXEC: begin
                    st_reg <= ST_OUT;
                    case (op_reg)
                        OP_WRITE: begin
                            ccol_reg <= nx_col[ColW-1:0];
                            if (nl) begin
                                if (ny >= maxy) begin
                                    if (maxy == rend) begin
                                        crow_reg <= RowW'(rend - 8'd1);
                                        srow_reg <= {1'b0, top_reg};
                                        send_reg <= 7'(rend - 8'd1);
                                        if (!rnum[7] && rnum > 8'd1) begin
                                            scr_reg <= 1'b1; st_reg <= ST_SCRL;
                                        end
                                    end else begin
                                        crow_reg <= RowW'(erows - 8'd1);
                                        srow_reg <= '0; send_reg <= 7'(erows - 8'd1);
                                        if (erows > 8'd1) begin
                                            scr_reg <= 1'b1; st_reg <= ST_SCRL;
                                        end
                                    end
                                    scol_reg <= '0; phase_reg <= 1'b0;
                                end else crow_reg <= ny[RowW-1:0];
                            end
                        end
                        OP_MOVE: begin
                            if ({2'b0, px_reg} < ecols) ccol_reg <= px_reg;
                            if ({2'b0, py_reg} < erows) crow_reg <= py_reg;
                        end
                        OP_CLEAR: begin
                            ccol_reg <= '0; crow_reg <= '0; srow_reg <= '0;
                            scol_reg <= '0; st_reg <= ST_CLR;
                        end
                        default: ;
                    endcase
                end
                ST_SCRL: begin
                    phase_reg <= !phase_reg;
                    if (phase_reg) begin
                        scol_reg <= scol_reg + 1'b1;
                        if (scol_reg == (ColW+1)'(MaxCols-1)) begin
                            scol_reg <= '0;
                            if (srow_reg + 7'd1 == send_reg) st_reg <= ST_FILL;
                            srow_reg <= srow_reg + 7'd1;
                        end
                    end
                end
                ST_FILL: begin
                    scol_reg <= scol_reg + 1'b1;
                    if (scol_reg + 1'b1 >= ecols) st_reg <= ST_OUT;
                end
                ST_CLR: begin
                    scol_reg <= scol_reg + 1'b1;
                    if (scol_reg + 1'b1 >= ecols) begin
                        scol_reg <= '0; srow_reg <= srow_reg + 7'd1;
                        if ({1'b0, srow_reg} + 8'd1 >= erows) st_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    out_reg <= {2'b0, cell_sel[23:16], cell_sel[15:8], cell_sel[7:0],
                                scr_reg, crow_reg, ccol_reg};
                    outv_reg <= 1'b1;
                    st_reg <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    `TCW_ASSERT_IMPL(a_no_take_busy, aclk, aresetn, s_tready, st_reg == ST_IDLE)
    `TCW_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))
    `TCW_ASSERT_IMPL(a_init_no_out, aclk, aresetn, st_reg == ST_INIT, !m_tvalid)
endmodule
`default_nettype wire

### bench/tb.sv
`default_nettype none
module tb;
    import tcw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [5:0] pos_y;
        logic [6:0] pos_x;
        logic [7:0] back_colour;
        logic [7:0] fore_colour;
        logic [7:0] char_code;
        logic [1:0] op;
    } cmd_t;

    typedef struct packed {
        logic [7:0] cell_back;
        logic [7:0] cell_fore;
        logic [7:0] cell_char;
        logic       did_scroll;
        logic [5:0] cur_row;
        logic [6:0] cur_col;
    } status_t;

    typedef struct {
        cmd_t    cmd;
        logic    typed;
        status_t want;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    text_console_cell_writer i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    logic [7:0] grid_char [MaxRows][MaxCols];
    logic [7:0] grid_fore [MaxRows][MaxCols];
    logic [7:0] grid_back [MaxRows][MaxCols];
    int unsigned crs_col, crs_row;
    int unsigned reg_cols, reg_rows, reg_top, reg_hgt;

    status_t status_q[$];
    int      errors;
    int      beats_out;
    int      scrolls_seen;
    bit      calm;
    bit      hold_rx;
    bit      hold_done;

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #200ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int unsigned span_cols();
        if (reg_cols == 0) return 1;
        return (reg_cols > MaxCols) ? MaxCols : reg_cols;
    endfunction

    function automatic int unsigned span_rows();
        if (reg_rows == 0) return 1;
        return (reg_rows > MaxRows) ? MaxRows : reg_rows;
    endfunction

    function automatic bit shift_rows(int start, int num, int rows, int cols,
                                      logic [7:0] fg, logic [7:0] bg);
        int last;
        if (num <= 0) num = rows - start;
        if (start + num > rows) num = rows - start;
        if (num <= 1) return 0;
        for (int r = start; r < start + num - 1; r++)
            for (int c = 0; c < MaxCols; c++) begin
                grid_char[r][c] = grid_char[r+1][c];
                grid_fore[r][c] = grid_fore[r+1][c];
                grid_back[r][c] = grid_back[r+1][c];
            end
        last = start + num - 1;
        for (int c = 0; c < cols; c++) begin
            grid_char[last][c] = BLANK;
            grid_fore[last][c] = fg;
            grid_back[last][c] = bg;
        end
        return 1;
    endfunction

    function automatic bit line_feed(int max_y, int reg_end, int rows, int cols,
                                     logic [7:0] fg, logic [7:0] bg);
        bit done;
        int y;
        done = 0;
        y = crs_row + 1;
        if (y >= max_y) begin
            if (max_y == reg_end) begin
                done = shift_rows(reg_top, reg_hgt, rows, cols, fg, bg);
                y = reg_end - 1;
            end else begin
                done = shift_rows(0, rows, rows, cols, fg, bg);
                y = rows - 1;
            end
        end
        if (y < 0) y = 0;
        crs_row = y;
        return done;
    endfunction

    function automatic bit put_char(cmd_t c);
        int cols, rows, start, num, reg_end, max_y;
        cols = span_cols();
        rows = span_rows();
        start = reg_top;
        num = reg_hgt;
        if (num <= 0) num = rows - start;
        if (start + num > rows) num = rows - start;
        reg_end = start + num;
        max_y = (int'(crs_row) >= start && int'(crs_row) < reg_end) ? reg_end : rows;
        case (c.char_code)
            CH_LF: begin
                crs_col = 0;
                return line_feed(max_y, reg_end, rows, cols, c.fore_colour, c.back_colour);
            end
            CH_CR: begin
                crs_col = 0;
                return 0;
            end
            CH_TAB: begin
                crs_col = (crs_col + 8) & ~32'd7;
                if (crs_col >= cols) begin
                    crs_col = 0;
                    return line_feed(max_y, reg_end, rows, cols,
                                     c.fore_colour, c.back_colour);
                end
                return 0;
            end
            CH_BS: begin
                if (crs_col > 0) crs_col--;
                return 0;
            end
            default: ;
        endcase
        if (crs_col < cols && crs_row < rows) begin
            grid_char[crs_row][crs_col] = c.char_code;
            grid_fore[crs_row][crs_col] = c.fore_colour;
            grid_back[crs_row][crs_col] = c.back_colour;
        end
        crs_col++;
        if (crs_col >= cols) begin
            crs_col = 0;
            return line_feed(max_y, reg_end, rows, cols, c.fore_colour, c.back_colour);
        end
        return 0;
    endfunction

    function automatic status_t console_step(cmd_t c);
        status_t s;
        s = '0;
        case (c.op)
            OP_WRITE: s.did_scroll = put_char(c);
            OP_MOVE: begin
                if (c.pos_x < span_cols()) crs_col = 32'(c.pos_x);
                if (c.pos_y < span_rows()) crs_row = 32'(c.pos_y);
            end
            OP_CLEAR: begin
                for (int r = 0; r < span_rows(); r++)
                    for (int k = 0; k < span_cols(); k++) begin
                        grid_char[r][k] = BLANK;
                        grid_fore[r][k] = DEF_FORE;
                        grid_back[r][k] = c.back_colour;
                    end
                crs_col = 0;
                crs_row = 0;
            end
            default: begin
                s.cell_char = grid_char[c.pos_y][c.pos_x];
                s.cell_fore = grid_fore[c.pos_y][c.pos_x];
                s.cell_back = grid_back[c.pos_y][c.pos_x];
            end
        endcase
        s.cur_col = crs_col[6:0];
        s.cur_row = crs_row[5:0];
        return s;
    endfunction

    task automatic send(cmd_t c);
        if (!calm) begin
            while ($urandom_range(99) < 15) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, c};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        status_q.push_back(console_step(c));
    endtask

    task automatic send_typed(cmd_t c, status_t w);
        status_t s;
        send(c);
        s = status_q.pop_back();
        if (s !== w) begin
            $error("typed row: expected %h, predictor %h", w, s);
            errors++;
        end
        status_q.push_back(w);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (status_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic reg_write(logic [1:0] idx, int unsigned val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_COLS: reg_cols = val & 8'hff;
            REG_ROWS: reg_rows = val & 7'h7f;
            REG_TOP:  reg_top = val & 6'h3f;
            default:  reg_hgt = val & 7'h7f;
        endcase
    endtask

    task automatic set_screen(int unsigned cols, int unsigned rows,
                              int unsigned top, int unsigned hgt);
        reg_write(REG_COLS, cols);
        reg_write(REG_ROWS, rows);
        reg_write(REG_TOP, top);
        reg_write(REG_HGT, hgt);
    endtask

    function automatic cmd_t mk(logic [1:0] op, logic [7:0] ch, logic [7:0] fg,
                                logic [7:0] bg, logic [6:0] x, logic [5:0] y);
        cmd_t c;
        c.op = op;
        c.char_code = ch;
        c.fore_colour = fg;
        c.back_colour = bg;
        c.pos_x = x;
        c.pos_y = y;
        return c;
    endfunction

    function automatic status_t st(int col, int row, logic [7:0] ch,
                                   logic [7:0] fg, logic [7:0] bg);
        status_t s;
        s = '0;
        s.cur_col = 7'(col);
        s.cur_row = 6'(row);
        s.cell_char = ch;
        s.cell_fore = fg;
        s.cell_back = bg;
        return s;
    endfunction

    function automatic cmd_t rand_cmd(int cols, int rows);
        cmd_t c;
        int k;
        c = 39'({$urandom, $urandom});
        k = $urandom_range(99);
        if (k < 55) begin
            c.op = OP_WRITE;
            case ($urandom_range(9))
                0: c.char_code = CH_LF;
                1: c.char_code = CH_TAB;
                2: c.char_code = CH_BS;
                3: c.char_code = CH_CR;
                default: ;
            endcase
        end else if (k < 70) begin
            c.op = OP_MOVE;
            if ($urandom_range(3) != 0) begin
                c.pos_x = 7'($urandom_range(cols - 1));
                c.pos_y = 6'($urandom_range(rows - 1));
            end
        end else if (k < 72) begin
            c.op = OP_CLEAR;
        end else begin
            c.op = OP_READ;
            if ($urandom_range(3) != 0) begin
                c.pos_x = 7'($urandom_range(cols - 1));
                c.pos_y = 6'($urandom_range(rows - 1));
            end
        end
        return c;
    endfunction

    always @(posedge aclk) begin
        status_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[37:0];
            beats_out++;
            if (status_q.size() == 0) begin
                $error("result beat with nothing expected: %h", got);
                errors++;
            end else begin
                want = status_q.pop_front();
                if (got.did_scroll) scrolls_seen++;
                if (got.cur_col !== want.cur_col) begin
                    $error("cur_col expected %0d got %0d", want.cur_col, got.cur_col);
                    errors++;
                end
                if (got.cur_row !== want.cur_row) begin
                    $error("cur_row expected %0d got %0d", want.cur_row, got.cur_row);
                    errors++;
                end
                if (got.did_scroll !== want.did_scroll) begin
                    $error("did_scroll expected %0d got %0d", want.did_scroll,
                           got.did_scroll);
                    errors++;
                end
                if (got.cell_char !== want.cell_char) begin
                    $error("cell_char expected %h got %h", want.cell_char, got.cell_char);
                    errors++;
                end
                if (got.cell_fore !== want.cell_fore) begin
                    $error("cell_fore expected %h got %h", want.cell_fore, got.cell_fore);
                    errors++;
                end
                if (got.cell_back !== want.cell_back) begin
                    $error("cell_back expected %h got %h", want.cell_back, got.cell_back);
                    errors++;
                end
            end
        end
    end

    initial begin
        int n;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_rx && !hold_done) begin
                m_tready <= 1'b0;
                n = 0;
                while (n < 300) begin
                    @(posedge aclk);
                    n++;
                end
                hold_done = 1;
            end
            m_tready <= calm || ($urandom_range(99) >= 15);
            @(posedge aclk);
        end
    end

    row_t plan[$];
    int unsigned dims[4][4] = '{
        '{8, 4, 1, 2}, '{1, 1, 0, 0}, '{255, 127, 63, 127}, '{128, 64, 2, 0}};

    initial begin
        cmd_t c;
        int cols, rows;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        aresetn = 1'b0;
        errors = 0;
        beats_out = 0;
        scrolls_seen = 0;
        calm = 0;
        hold_rx = 0;
        hold_done = 0;
        for (int r = 0; r < MaxRows; r++)
            for (int k = 0; k < MaxCols; k++) begin
                grid_char[r][k] = BLANK;
                grid_fore[r][k] = DEF_FORE;
                grid_back[r][k] = 8'h00;
            end
        crs_col = 0;
        crs_row = 0;
        reg_cols = 80;
        reg_rows = 25;
        reg_top = 0;
        reg_hgt = 25;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        plan.push_back('{mk(OP_READ, 0, 0, 0, 0, 0), 1, st(0, 0, BLANK, DEF_FORE, 0)});
        plan.push_back('{mk(OP_READ, 0, 0, 0, 127, 63), 1, st(0, 0, BLANK, DEF_FORE, 0)});
        plan.push_back('{mk(OP_WRITE, 8'hff, 8'hff, 8'hff, 0, 0), 1, st(1, 0, 0, 0, 0)});
        plan.push_back('{mk(OP_READ, 0, 0, 0, 0, 0), 1, st(1, 0, 8'hff, 8'hff, 8'hff)});
        plan.push_back('{mk(OP_WRITE, 0, 0, 0, 0, 0), 1, st(2, 0, 0, 0, 0)});
        plan.push_back('{mk(OP_WRITE, CH_BS, 1, 2, 0, 0), 1, st(1, 0, 0, 0, 0)});
        plan.push_back('{mk(OP_WRITE, CH_TAB, 1, 2, 0, 0), 1, st(8, 0, 0, 0, 0)});
        plan.push_back('{mk(OP_WRITE, CH_CR, 1, 2, 0, 0), 1, st(0, 0, 0, 0, 0)});
        plan.push_back('{mk(OP_WRITE, CH_BS, 1, 2, 0, 0), 1, st(0, 0, 0, 0, 0)});
        plan.push_back('{mk(OP_WRITE, CH_LF, 1, 2, 0, 0), 1, st(0, 1, 0, 0, 0)});
        plan.push_back('{mk(OP_MOVE, 0, 0, 0, 79, 24), 1, st(79, 24, 0, 0, 0)});
        plan.push_back('{mk(OP_MOVE, 0, 0, 0, 127, 63), 1, st(79, 24, 0, 0, 0)});
        plan.push_back('{mk(OP_WRITE, 8'h41, 3, 4, 0, 0), 0, '0});
        plan.push_back('{mk(OP_READ, 0, 0, 0, 79, 23), 0, '0});
        plan.push_back('{mk(OP_WRITE, CH_TAB, 5, 6, 0, 0), 0, '0});
        plan.push_back('{mk(OP_CLEAR, 0, 0, 8'h5a, 0, 0), 1, st(0, 0, 0, 0, 0)});
        plan.push_back('{mk(OP_READ, 0, 0, 0, 79, 24), 1, st(0, 0, BLANK, DEF_FORE, 8'h5a)});
        plan.push_back('{mk(OP_READ, 0, 0, 0, 80, 24), 1, st(0, 0, BLANK, DEF_FORE, 0)});
        plan.push_back('{mk(OP_MOVE, 0, 0, 0, 7'h2a, 6'h15), 1, st(42, 21, 0, 0, 0)});
        plan.push_back('{mk(OP_MOVE, 0, 0, 0, 7'h55, 6'h2a), 1, st(42, 21, 0, 0, 0)});
        foreach (plan[i]) begin
            if (plan[i].typed) send_typed(plan[i].cmd, plan[i].want);
            else send(plan[i].cmd);
        end
        drain();

        // region scrolls, whole-screen scrolls, then cursor outside the shrunk screen
        set_screen(8, 6, 2, 2);
        send(mk(OP_MOVE, 0, 0, 0, 7, 3));
        send(mk(OP_WRITE, 8'h42, 9, 10, 0, 0));
        send(mk(OP_MOVE, 0, 0, 0, 0, 5));
        send(mk(OP_WRITE, CH_LF, 11, 12, 0, 0));
        send(mk(OP_MOVE, 0, 0, 0, 0, 2));
        send(mk(OP_WRITE, CH_TAB, 13, 14, 0, 0));
        send(mk(OP_READ, 0, 0, 0, 0, 2));
        send(mk(OP_MOVE, 0, 0, 0, 5, 5));
        drain();
        set_screen(4, 3, 63, 64);
        send(mk(OP_WRITE, 8'h43, 1, 1, 0, 0));
        send(mk(OP_WRITE, CH_LF, 2, 2, 0, 0));
        send(mk(OP_READ, 0, 0, 0, 5, 5));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            set_screen(dims[ph][0], dims[ph][1], dims[ph][2], dims[ph][3]);
            cols = (dims[ph][0] == 0) ? 1 : (dims[ph][0] > MaxCols ? MaxCols : dims[ph][0]);
            rows = (dims[ph][1] == 0) ? 1 : (dims[ph][1] > MaxRows ? MaxRows : dims[ph][1]);
            if (ph == 1) calm = 1;
            if (ph == 2) begin
                calm = 0;
                hold_rx = 1;
            end
            for (int i = 0; i < 230; i++) begin
                c = rand_cmd(cols, rows);
                if (ph >= 2 && c.op == OP_CLEAR && $urandom_range(3) != 0) c.op = OP_READ;
                send(c);
            end
            drain();
        end
        set_screen(16, 8, 3, 3);
        for (int i = 0; i < 40; i++) send(rand_cmd(16, 8));
        drain();

        $display("Covered %0d result beats over eight screen setups, %0d of them scrolled.",
                 beats_out, scrolls_seen);
        if (errors == 0 && status_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
+incdir+rtl
rtl/tcw_pkg.sv
rtl/text_console_cell_writer.sv
bench/tb.sv
